// File: design/coalescing_request_queue_macros.svh
// ----------------------------------------------------------------------------
// coalescing request queue assertion macros
// shared concurrent assertion forms, clocked on rising edge, reset masked
// ----------------------------------------------------------------------------
`ifndef COALESCING_REQUEST_QUEUE_MACROS_SVH
`define COALESCING_REQUEST_QUEUE_MACROS_SVH

// same-cycle implication
`define CRQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/crq_pkg.sv
// ----------------------------------------------------------------------------
// crq_pkg
// sizes, command and status codes and helpers of the coalescing request queue
// ----------------------------------------------------------------------------
package crq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 64;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W = 2;
  localparam int STS_W = 3;
  localparam int OCC_W = 5;
  localparam int CFG_W = 5;
  localparam int KEY_W = 64;

  localparam logic [CFG_W-1:0] CAP_LIMIT_RST = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_TAKE  = 2'd1,
    CMD_DRAIN = 2'd2
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_COALESCED = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_TAKEN     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_TAKE
  } state_t;

  // ring pointer advance with wrap at the queue depth
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

endpackage

// File: design/coalescing_request_queue.sv
// drop, drain, empty take and enqueue into an empty queue strobe their result
//   in the cycle after the start transfer; a take reads the head, then strobes from S_TAKE
// an enqueue into a non-empty queue walks the waiting keys through one comparator,
//   a memory read (S_RD) then a compare (S_CMP) per key, until a match or the last key
// throughput: one command at a time; busy drops in the strobe cycle, receiver cannot stall
// reset (rst_n low, synchronous): queue empty, accepting enqueues, capacity limit 16
// ----------------------------------------------------------------------------
// coalescing_request_queue
// bounded fifo of request keys; a key already waiting is coalesced, not stored
// twice. take pops the oldest key, drain stops further enqueues
// ----------------------------------------------------------------------------
`include "coalescing_request_queue_macros.svh"

module coalescing_request_queue
  import crq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // command channel
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] in_cmd,
  input  logic             in_key_present,
  input  logic [KEY_W-1:0] in_key,
  // result channel
  output logic             out_strobe,
  output logic [STS_W-1:0] out_status,
  output logic [KEY_W-1:0] out_taken_key,
  output logic [OCC_W-1:0] out_occupancy,
  // configuration
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // key storage, read data registered
  logic [KEY_BITS-1:0] mem [QUEUE_DEPTH];
  logic [KEY_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [KEY_BITS-1:0] wr_data;

  // control state
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accepting_r, accepting_nxt;
  logic [CFG_W-1:0] cap_limit_r;

  // scan walker
  logic [IDX_W-1:0]    scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;

  // result registers
  logic                out_strobe_r;
  status_t             out_status_r;
  logic [KEY_W-1:0]    out_taken_key_r;
  logic [OCC_W-1:0]    out_occupancy_r;
  logic                res_valid;
  status_t             res_status;
  logic [KEY_W-1:0]    res_taken;

  // decode
  logic acc;
  cmd_t cmd_in;
  logic full;
  logic scan_need;
  logic take_need;
  logic hit;
  logic last;

  assign busy      = (state_r != S_IDLE);
  assign acc       = start && !busy;
  assign cmd_in    = cmd_t'(in_cmd);
  // capacity above the depth acts as the depth
  assign full      = (32'(count_r) >= 32'(cap_limit_r)) || (32'(count_r) >= QUEUE_DEPTH);
  assign scan_need = acc && (cmd_in == CMD_ENQ) && in_key_present && accepting_r
                     && (count_r != '0);
  assign take_need = acc && (cmd_in == CMD_TAKE) && (count_r != '0);
  // the one shared comparator
  assign hit       = (rd_data_r == key_r);
  assign last      = (left_r == CNT_W'(1));

  // read port: scan pointer while walking, else the head for a take
  assign rd_addr = (state_r == S_RD) ? scan_ptr_r : head_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (scan_need) begin
          state_nxt = S_RD;
        end else if (take_need) begin
          state_nxt = S_TAKE;
        end
      end
      S_RD:   state_nxt = S_CMP;
      S_CMP: begin
        if (hit || last) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_TAKE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    accepting_nxt = accepting_r;
    scan_ptr_nxt  = scan_ptr_r;
    left_nxt      = left_r;
    key_nxt       = key_r;
    wr_en         = 1'b0;
    wr_data       = key_r;
    res_valid     = 1'b0;
    res_status    = ST_DROPPED;
    res_taken     = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          case (cmd_in)
            CMD_ENQ: begin
              if (!in_key_present || !accepting_r) begin
                res_valid = 1'b1;
              end else if (count_r == '0) begin
                // nothing waiting, no walk needed
                res_valid = 1'b1;
                if (!full) begin
                  wr_en      = 1'b1;
                  wr_data    = in_key[KEY_BITS-1:0];
                  tail_nxt   = next_slot(tail_r);
                  count_nxt  = count_r + 1'b1;
                  res_status = ST_ENQUEUED;
                end
              end else begin
                key_nxt      = in_key[KEY_BITS-1:0];
                scan_ptr_nxt = head_r;
                left_nxt     = count_r;
              end
            end
            CMD_TAKE: begin
              if (count_r == '0) begin
                res_valid  = 1'b1;
                res_status = ST_EMPTY;
              end
            end
            CMD_DRAIN: begin
              accepting_nxt = 1'b0;
              res_valid     = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
      end
      S_CMP: begin
        if (hit) begin
          res_valid  = 1'b1;
          res_status = ST_COALESCED;
        end else if (last) begin
          // not waiting: capacity check, then append at the tail
          res_valid = 1'b1;
          if (!full) begin
            wr_en      = 1'b1;
            tail_nxt   = next_slot(tail_r);
            count_nxt  = count_r + 1'b1;
            res_status = ST_ENQUEUED;
          end
        end else begin
          scan_ptr_nxt = next_slot(scan_ptr_r);
          left_nxt     = left_r - 1'b1;
        end
      end
      S_TAKE: begin
        res_valid  = 1'b1;
        res_status = ST_TAKEN;
        res_taken  = KEY_W'(rd_data_r);
        head_nxt   = next_slot(head_r);
        count_nxt  = count_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      accepting_r  <= 1'b1;
      cap_limit_r  <= CAP_LIMIT_RST;
      scan_ptr_r   <= '0;
      left_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      accepting_r  <= accepting_nxt;
      scan_ptr_r   <= scan_ptr_nxt;
      left_r       <= left_nxt;
      out_strobe_r <= res_valid;
      if (cfg_we) begin
        cap_limit_r <= cfg_wdata;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (res_valid) begin
      out_status_r    <= res_status;
      out_taken_key_r <= res_taken;
      out_occupancy_r <= OCC_W'(count_nxt);
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_taken_key = out_taken_key_r;
  assign out_occupancy = out_occupancy_r;

  // assertions
  `CRQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, 32'(count_r) <= QUEUE_DEPTH,
    "waiting count exceeds queue depth")
  `CRQ_ASSERT_NXT(a_take_empty, clk, rst_n,
    start && !busy && (in_cmd == CMD_TAKE) && (count_r == '0),
    out_strobe && (out_status == ST_EMPTY), "take on empty queue not reported")
  `CRQ_ASSERT_IMP(a_strobe_cause, clk, rst_n, out_strobe,
    $past(state_r != S_IDLE) || $past(start), "result strobe without a command")
  `CRQ_ASSERT_IMP(a_drain_only, clk, rst_n, $fell(accepting_r),
    $past(start && !busy && (in_cmd == CMD_DRAIN)), "accepting cleared without drain")

endmodule
